/* rtl/bcg_pkg.sv */
package bcg_pkg;

  // converter and measurement widths
  localparam int unsigned AdcW   = 12;
  localparam int unsigned SumW   = 20;
  localparam int unsigned CountW = 8;
  localparam int unsigned GainW  = 16;
  localparam int unsigned MvW    = 16;
  localparam int unsigned RiseW  = 8;
  localparam int unsigned PctW   = 7;
  localparam int unsigned LevelW = 3;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned GainFracBits = 12;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgSampleCount = 2'd0,
    CfgDividerGain = 2'd1,
    CfgChargeRise  = 2'd2
  } cfg_idx_e;

  localparam logic [CountW-1:0] SampleCountRst  = 8'd16;
  localparam logic [GainW-1:0]  DividerGainRst  = 16'd8192;
  localparam logic [RiseW-1:0]  ChargeRiseRst   = 8'd20;

  // discharge curve of a single lipo cell, spans between points stay below 256 mv
  localparam int unsigned CurvePoints = 17;
  localparam int unsigned CurveIdxW   = $clog2(CurvePoints);
  localparam int unsigned SpanW       = 8;

  localparam logic [MvW-1:0] CurveMv [CurvePoints] = '{
    16'd3000, 16'd3200, 16'd3300, 16'd3400, 16'd3500, 16'd3600,
    16'd3700, 16'd3750, 16'd3800, 16'd3850, 16'd3900, 16'd3950,
    16'd4000, 16'd4050, 16'd4100, 16'd4150, 16'd4200
  };
  localparam logic [PctW-1:0] CurvePct [CurvePoints] = '{
    7'd0,  7'd5,  7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd55, 7'd60,
    7'd68, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd98, 7'd100
  };

  localparam logic [PctW-1:0] PctEmpty = 7'd0;
  localparam logic [PctW-1:0] PctFull  = 7'd100;

  // level thresholds, percent strictly above
  localparam logic [PctW-1:0] LevelThr1 = 7'd10;
  localparam logic [PctW-1:0] LevelThr2 = 7'd25;
  localparam logic [PctW-1:0] LevelThr3 = 7'd50;
  localparam logic [PctW-1:0] LevelThr4 = 7'd75;

  typedef enum logic [LevelW-1:0] {
    LevelEmpty    = 3'd0,
    LevelBar1     = 3'd1,
    LevelBar2     = 3'd2,
    LevelBar3     = 3'd3,
    LevelFull     = 3'd4,
    LevelCharging = 3'd5
  } level_e;

endpackage

/* rtl/battery_charge_gauge_top.sv */
// battery charge gauge
//
// input channel: one adc sample in millivolts per transaction (in_valid_i, in_stall_o).
// after sample_count samples the sum is averaged, scaled by the q4.12 divider gain,
// mapped to percent on the lipo curve and offered as one output transaction
// (out_valid_o, out_stall_i). samples that do not close a measurement give no result.
// a sample that does not close a measurement is added to the sum without a stall. the closing
// sample starts a sequence of one-bit-per-cycle steps: a restoring divider for the
// average, a shift-add multiplier for the gain, a saturation and charge check,
// a curve scan of one point per cycle and a second pass through the same divider
// for the interpolation. voltages at or beyond the ends of the curve skip scan and
// interpolation. the result register loads at the end of this sequence; in_stall_o
// is high for that whole sequence, so one measurement is worked on at a time.
// the result register parts the two sides: samples keep flowing while a result waits;
// a finished measurement waits in its last step while out_stall_i holds the register.
// configuration writes are taken any cycle through cfg_we_i; index 3 is ignored.
// reset clears sums, history, the result register and loads the register defaults.
module battery_charge_gauge_top
  import bcg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [AdcW-1:0]   adc_millivolts_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MvW-1:0]    battery_mv_o,
  output logic [PctW-1:0]   charge_percent_o,
  output logic              is_charging_o,
  output logic [LevelW-1:0] level_code_o
);

  localparam int unsigned StepW   = $clog2(SumW);
  localparam int unsigned ProdW   = SumW + GainW;
  localparam int unsigned RemW    = SpanW;

  typedef enum logic [2:0] {
    StIdle,
    StDivAvg,
    StMul,
    StSat,
    StScan,
    StDivInt,
    StDone
  } state_e;

  state_e state_q;

  // configuration
  logic [CountW-1:0] sample_count_q;
  logic [GainW-1:0]  divider_gain_q;
  logic [RiseW-1:0]  charge_rise_q;

  // accumulation and history
  logic [SumW-1:0]   sample_sum_q;
  logic [CountW-1:0] sample_counter_q;
  logic [MvW-1:0]    older_mv_q;
  logic [MvW-1:0]    latest_mv_q;
  logic              baseline_done_q;

  // datapath
  logic [SumW-1:0]      div_q;      // dividend bits out, quotient bits in
  logic [RemW-1:0]      rem_q;
  logic [SpanW-1:0]     dvsr_q;
  logic [StepW-1:0]     step_q;
  logic [ProdW-1:0]     prod_q;
  logic [GainW-1:0]     gain_sr_q;
  logic [MvW-1:0]       mv_q;
  logic                 charging_q;
  logic [CurveIdxW-1:0] idx_q;
  logic [PctW-1:0]      base_pct_q;
  logic [PctW-1:0]      pct_q;

  // result register
  logic              out_valid_q;
  logic [MvW-1:0]    out_mv_q;
  logic [PctW-1:0]   out_pct_q;
  logic              out_chg_q;
  level_e            out_level_q;

  logic              in_acc;
  logic [CountW-1:0] count_eff;
  logic [SumW-1:0]   sum_d;
  logic [CountW-1:0] counter_d;
  logic              meas_done;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign count_eff  = (sample_count_q == '0) ? CountW'(1) : sample_count_q;
  assign sum_d      = sample_sum_q + SumW'(adc_millivolts_i);
  assign counter_d  = sample_counter_q + CountW'(1);
  assign meas_done  = (counter_d == '0) || (counter_d >= count_eff);

  // one restoring divider step
  logic [RemW:0]   rem_sh;
  logic            div_ge;
  logic [RemW:0]   rem_sub;
  logic [RemW-1:0] rem_d;
  logic [SumW-1:0] div_d;
  logic            step_last_div;

  assign rem_sh        = {rem_q, div_q[SumW-1]};
  assign div_ge        = rem_sh >= {1'b0, dvsr_q};
  assign rem_sub       = rem_sh - {1'b0, dvsr_q};
  assign rem_d         = div_ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
  assign div_d         = {div_q[SumW-2:0], div_ge};
  assign step_last_div = (step_q == StepW'(SumW - 1));

  // one shift-add multiplier step, gain bits lsb first
  logic [SumW:0]    mul_sum;
  logic [ProdW-1:0] prod_d;
  logic             step_last_mul;

  assign mul_sum       = {1'b0, prod_q[ProdW-1:GainW]} +
                         (gain_sr_q[0] ? {1'b0, div_q} : '0);
  assign prod_d        = {mul_sum, prod_q[GainW-1:1]};
  assign step_last_mul = (step_q == StepW'(GainW - 1));

  // saturation of the scaled voltage
  logic [MvW-1:0] mv_sat;
  assign mv_sat = (prod_q[ProdW-1:GainFracBits+MvW] != '0) ? '1 :
                  prod_q[GainFracBits+MvW-1:GainFracBits];

  logic [MvW:0] rise_limit;
  assign rise_limit = {1'b0, older_mv_q} + (MvW+1)'(charge_rise_q);

  // curve segment for the scan
  logic [CurveIdxW-1:0] idx_prev;
  logic [MvW-1:0]       span_mv_full;
  logic [MvW-1:0]       off_full;
  logic [PctW-1:0]      span_pct;
  logic [SpanW+PctW-1:0] interp_num;

  assign idx_prev     = idx_q - CurveIdxW'(1);
  assign span_mv_full = CurveMv[idx_q] - CurveMv[idx_prev];
  assign off_full     = mv_q - CurveMv[idx_prev];
  assign span_pct     = CurvePct[idx_q] - CurvePct[idx_prev];
  assign interp_num   = off_full[SpanW-1:0] * span_pct;

  function automatic level_e to_level(input logic chg, input logic [PctW-1:0] pct);
    level_e lv;
    if (chg)                  lv = LevelCharging;
    else if (pct > LevelThr4) lv = LevelFull;
    else if (pct > LevelThr3) lv = LevelBar3;
    else if (pct > LevelThr2) lv = LevelBar2;
    else if (pct > LevelThr1) lv = LevelBar1;
    else                      lv = LevelEmpty;
    return lv;
  endfunction

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // control, history and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      sample_count_q   <= SampleCountRst;
      divider_gain_q   <= DividerGainRst;
      charge_rise_q    <= ChargeRiseRst;
      sample_sum_q     <= '0;
      sample_counter_q <= '0;
      older_mv_q       <= '0;
      latest_mv_q      <= '0;
      baseline_done_q  <= 1'b0;
      out_valid_q      <= 1'b0;
      out_mv_q         <= '0;
      out_pct_q        <= '0;
      out_chg_q        <= 1'b0;
      out_level_q      <= LevelEmpty;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSampleCount: sample_count_q <= cfg_wdata_i[CountW-1:0];
          CfgDividerGain: divider_gain_q <= cfg_wdata_i[GainW-1:0];
          CfgChargeRise:  charge_rise_q  <= cfg_wdata_i[RiseW-1:0];
          default: ;
        endcase
      end

      // a finished measurement loads when the register is free, else an accepted one leaves
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (meas_done) begin
              sample_sum_q     <= '0;
              sample_counter_q <= '0;
              state_q          <= StDivAvg;
            end else begin
              sample_sum_q     <= sum_d;
              sample_counter_q <= counter_d;
            end
          end
        end
        StDivAvg: begin
          if (step_last_div) state_q <= StMul;
        end
        StMul: begin
          if (step_last_mul) state_q <= StSat;
        end
        StSat: begin
          if (!baseline_done_q) begin
            older_mv_q      <= mv_sat;
            baseline_done_q <= 1'b1;
          end else begin
            older_mv_q <= latest_mv_q;
          end
          latest_mv_q <= mv_sat;
          if (mv_sat <= CurveMv[0] || mv_sat >= CurveMv[CurvePoints-1]) begin
            state_q <= StDone;
          end else begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (mv_q <= CurveMv[idx_q]) begin
            state_q <= (span_mv_full == '0) ? StDone : StDivInt;
          end
        end
        StDivInt: begin
          if (step_last_div) state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_mv_q    <= mv_q;
            out_pct_q   <= pct_q;
            out_chg_q   <= charging_q;
            out_level_q <= to_level(charging_q, pct_q);
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        div_q  <= sum_d;
        rem_q  <= '0;
        dvsr_q <= count_eff;
        step_q <= '0;
      end
      StDivAvg: begin
        div_q  <= div_d;
        rem_q  <= rem_d;
        step_q <= step_last_div ? '0 : step_q + StepW'(1);
        prod_q    <= '0;
        gain_sr_q <= divider_gain_q;
      end
      StMul: begin
        prod_q    <= prod_d;
        gain_sr_q <= {1'b0, gain_sr_q[GainW-1:1]};
        step_q    <= step_q + StepW'(1);
      end
      StSat: begin
        mv_q       <= mv_sat;
        charging_q <= baseline_done_q && ({1'b0, mv_sat} > rise_limit);
        pct_q      <= (mv_sat <= CurveMv[0]) ? PctEmpty : PctFull;
        idx_q      <= CurveIdxW'(1);
      end
      StScan: begin
        if (mv_q <= CurveMv[idx_q]) begin
          div_q      <= SumW'(interp_num);
          rem_q      <= '0;
          dvsr_q     <= span_mv_full[SpanW-1:0];
          step_q     <= '0;
          base_pct_q <= CurvePct[idx_prev];
          pct_q      <= CurvePct[idx_q];
        end else begin
          idx_q <= idx_q + CurveIdxW'(1);
        end
      end
      StDivInt: begin
        div_q  <= div_d;
        rem_q  <= rem_d;
        step_q <= step_q + StepW'(1);
        if (step_last_div) begin
          pct_q <= base_pct_q + div_d[PctW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign battery_mv_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;
  assign is_charging_o    = out_chg_q;
  assign level_code_o     = out_level_q;

endmodule

/* rtl/bcg_chk.sv */
module bcg_chk
  import bcg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MvW-1:0]    battery_mv_o,
  input logic [PctW-1:0]   charge_percent_o,
  input logic              is_charging_o,
  input logic [LevelW-1:0] level_code_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(battery_mv_o) &&
      $stable(charge_percent_o) && $stable(is_charging_o) && $stable(level_code_o))
    else $error("result changed while stalled");

  // charging code appears exactly with the charging flag
  a_chg_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_charging_o == (level_code_o == LevelW'(LevelCharging))))
    else $error("charging flag and level code disagree");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_percent_o <= PctFull)
    else $error("percent above full");

  // voltages at the bottom of the curve read as empty
  a_low_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && battery_mv_o <= CurveMv[0] |-> charge_percent_o == PctEmpty)
    else $error("low voltage not clamped to empty");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_charging_o && charge_percent_o > LevelThr4
      |-> level_code_o == LevelW'(LevelFull))
    else $error("full level code missing");

endmodule

bind battery_charge_gauge_top bcg_chk u_bcg_chk (.*);
